FILE: rtl/imt_pkg.sv
// ----------------------------------------------------------------------------
// imt_pkg
// Shared types, sizes, operation codes and the exp(-x) acceptance table
// of the Ising Metropolis / tempering core.
// ----------------------------------------------------------------------------
package imt_pkg;

  // Problem size
  localparam int SPINS       = 64;
  localparam int TEMPS       = 16;
  localparam int REPLICAS    = 2;
  localparam int EXP_ENTRIES = 256;

  localparam int SPIN_W  = $clog2(SPINS);
  localparam int SLOT_W  = $clog2(TEMPS);
  localparam int SLOTS   = REPLICAS * TEMPS;
  localparam int SLOTS_W = $clog2(SLOTS);

  localparam int BOND_DEPTH = SPINS * SPINS;
  localparam int BOND_AW    = $clog2(BOND_DEPTH);
  localparam int SPIN_DEPTH = SLOTS * SPINS;
  localparam int SPIN_AW    = $clog2(SPIN_DEPTH);

  // Datapath widths
  localparam int BOND_W = 16;
  localparam int RSUM_W = 24;
  localparam int EN_W   = 32;
  localparam int BETA_W = 16;
  localparam int RAND_W = 16;
  localparam int ALU_W  = 36;
  localparam int DE_W   = 33;
  localparam int MULB_W = BETA_W + 2;
  localparam int PROD_W = 50;

  // Exp table: entry k ~ 65536 * exp(-k/16)
  localparam int    EXP_AW   = $clog2(EXP_ENTRIES);
  localparam int    EXP_DW   = RAND_W + 1;
  localparam longint EXP_STEP = 64'd4034748382;

  // Operation codes
  localparam logic [2:0] FN_BOND   = 3'd0;
  localparam logic [2:0] FN_SPIN   = 3'd1;
  localparam logic [2:0] FN_BETA   = 3'd2;
  localparam logic [2:0] FN_ENERGY = 3'd3;
  localparam logic [2:0] FN_METRO  = 3'd4;
  localparam logic [2:0] FN_TEMPER = 3'd5;

  // Shared adder operations
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

  typedef struct packed {
    logic [2:0]               func;
    logic                     replica_sel;
    logic [3:0]               slot_sel;
    logic [5:0]               row_idx;
    logic [5:0]               col_idx;
    logic signed [15:0]       data_value;
    logic [15:0]              rand_value;
  } imt_in_t;

  typedef struct packed {
    logic                     accepted;
    logic signed [31:0]       slot_energy_out;
    logic signed [31:0]       delta_out;
  } imt_out_t;

  typedef logic [EXP_DW-1:0] exp_tab_t [EXP_ENTRIES];

  // Q0.32 recurrence a_{k+1} = round(a_k * exp(-1/16)), rounded to Q0.16
  function automatic exp_tab_t exp_tab_build();
    exp_tab_t     t;
    logic [127:0] acc;
    acc = 128'd1 << 32;
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      t[k] = EXP_DW'((acc + 128'h8000) >> 16);
      acc  = (acc * 128'(EXP_STEP) + (128'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_build();

  // Accept when rnd < exp(-x), x in Q30.20 and nonnegative
  function automatic logic exp_accept(input logic [PROD_W-1:0] x,
                                      input logic [RAND_W-1:0] rnd);
    logic [PROD_W-17:0] k;
    k = x[PROD_W-1:16];
    if (k >= (PROD_W-16)'(EXP_ENTRIES)) return 1'b0;
    return {1'b0, rnd} < EXP_TAB[k[EXP_AW-1:0]];
  endfunction

  // Saturate to 32 bits signed
  function automatic logic signed [EN_W-1:0] sat32(input logic signed [ALU_W-1:0] v);
    if (v[ALU_W-1:EN_W-1] == '0 || v[ALU_W-1:EN_W-1] == '1) return v[EN_W-1:0];
    if (v[ALU_W-1]) return {1'b1, {(EN_W-1){1'b0}}};
    return {1'b0, {(EN_W-1){1'b1}}};
  endfunction

endpackage

FILE: rtl/imt_ram.sv
// ----------------------------------------------------------------------------
// imt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/imt_alu.sv
// ----------------------------------------------------------------------------
// imt_alu
// Shared signed add/subtract unit used by the bond, energy, Metropolis and tempering steps of the sequencer.
// ----------------------------------------------------------------------------
module imt_alu (
  input  imt_pkg::alu_op_t                 op,
  input  logic signed [imt_pkg::ALU_W-1:0] a,
  input  logic signed [imt_pkg::ALU_W-1:0] b,
  output logic signed [imt_pkg::ALU_W-1:0] y
);
  import imt_pkg::*;

  always_comb begin
    case (op)
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

FILE: rtl/ising_metropolis_tempering_core.sv
// ----------------------------------------------------------------------------
// ising_metropolis_tempering_core
// Ising spin-glass Metropolis engine with replica-exchange tempering.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one command per
//   transaction (bond write, spin write, beta write, energy recompute,
//   Metropolis trial, tempering trial). Every command returns exactly one
//   transaction on out_valid/out_stall/out_data.
//   in_stall is high whenever a command is in progress; one command is
//   processed at a time. A Metropolis trial makes one bond/spin memory
//   read per spin; an energy recompute makes one read per bond on or
//   above the diagonal, plus a gap and an accumulate step per row, all
//   through the one shared adder.
//   After reset a clearing pass zeroes the bond, spin and row-sum
//   memories; in_stall stays high meanwhile.
//   A finished result waits in the output register while out_stall is
//   high; the next command may be accepted meanwhile, but its result is
//   held back until the waiting one has been handed over.
// ----------------------------------------------------------------------------
module ising_metropolis_tempering_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  imt_pkg::imt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output imt_pkg::imt_out_t out_data
);
  import imt_pkg::*;

  // Sequencer states
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_MAP    = 5'd2;
  localparam logic [4:0] S_BW0    = 5'd3;
  localparam logic [4:0] S_BW1    = 5'd4;
  localparam logic [4:0] S_BW2    = 5'd5;
  localparam logic [4:0] S_BW3    = 5'd6;
  localparam logic [4:0] S_BW4    = 5'd7;
  localparam logic [4:0] S_ER_ISS = 5'd8;
  localparam logic [4:0] S_ER_GAP = 5'd9;
  localparam logic [4:0] S_ER_ACC = 5'd10;
  localparam logic [4:0] S_M_ISS  = 5'd11;
  localparam logic [4:0] S_M_GAP  = 5'd12;
  localparam logic [4:0] S_M_DE   = 5'd13;
  localparam logic [4:0] S_M_MUL  = 5'd14;
  localparam logic [4:0] S_M_DEC  = 5'd15;
  localparam logic [4:0] S_T0     = 5'd16;
  localparam logic [4:0] S_T1     = 5'd17;
  localparam logic [4:0] S_T2     = 5'd18;
  localparam logic [4:0] S_T3     = 5'd19;
  localparam logic [4:0] S_T4     = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  localparam logic [SPIN_W-1:0] LAST_SPIN = SPIN_W'(SPINS - 1);
  localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(TEMPS - 1);

  // Control registers
  logic [4:0]         state_r;
  logic [BOND_AW-1:0] clr_r;
  logic [SPIN_W-1:0]  i_r;
  logic [SPIN_W-1:0]  j_r;
  logic               p_vld_r;
  logic               out_valid_r;
  logic [SLOT_W-1:0]  map_r [SLOTS];

  // Payload registers
  imt_in_t                   item_r;
  imt_out_t                  out_data_r;
  logic [SLOT_W-1:0]         bank_r;
  logic                      p_diag_r;
  logic signed [RSUM_W-1:0]  tmp_r;
  logic signed [RSUM_W-1:0]  row_acc_r;
  logic signed [RSUM_W-1:0]  sum_r;
  logic signed [EN_W-1:0]    e_acc_r;
  logic                      si_r;
  logic                      c_row_r;
  logic signed [DE_W-1:0]    de_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [BETA_W:0]    bd_r;
  logic [BETA_W-1:0]         beta_a_r;
  logic signed [EN_W-1:0]    ea_r;
  logic signed [EN_W-1:0]    eb_r;
  logic [SLOT_W-1:0]         ma_r;
  logic [SLOT_W-1:0]         mb_r;
  logic                      acc_r;
  logic signed [EN_W-1:0]    delta_r;
  logic signed [EN_W-1:0]    en_r [SLOTS];
  logic [BETA_W-1:0]         beta_r [TEMPS];

  // Combinational signals
  logic                      in_fire;
  logic [SLOT_W-1:0]         rd_slot;
  logic [SLOTS_W-1:0]        rd_idx;
  logic [SLOTS_W-1:0]        pair_idx;
  logic [BETA_W-1:0]         beta_rd;
  logic signed [EN_W-1:0]    en_rd;
  logic [SLOT_W-1:0]         map_rd;
  alu_op_t                   alu_op;
  logic signed [ALU_W-1:0]   alu_a;
  logic signed [ALU_W-1:0]   alu_b;
  logic signed [ALU_W-1:0]   alu_y;
  logic                      bond_we;
  logic [BOND_AW-1:0]        bond_waddr;
  logic [BOND_W-1:0]         bond_wdata;
  logic [BOND_AW-1:0]        bond_raddr;
  logic [BOND_W-1:0]         bond_rdata;
  logic signed [BOND_W-1:0]  bond_j;
  logic                      spin_we;
  logic [SPIN_AW-1:0]        spin_waddr;
  logic                      spin_wdata;
  logic [SPIN_AW-1:0]        spin_raddr;
  logic                      spin_rdata;
  logic                      rs_we;
  logic [SPIN_W-1:0]         rs_waddr;
  logic [RSUM_W-1:0]         rs_wdata;
  logic [SPIN_W-1:0]         rs_raddr;
  logic [RSUM_W-1:0]         rs_rdata;
  logic signed [RSUM_W-1:0]  rs_val;
  logic                      data_phase;
  logic                      er_phase;
  logic signed [MULB_W-1:0]  mul_b;
  logic signed [PROD_W:0]    prod_full;
  logic [PROD_W-1:0]         x_abs;
  logic                      exp_ok;
  logic                      m_ok;
  logic                      t_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Slot-indexed register reads: upper slot of the pair only in T1
  assign rd_slot  = (state_r == S_T1) ? item_r.slot_sel + 1'b1 : item_r.slot_sel;
  assign rd_idx   = {item_r.replica_sel, rd_slot};
  assign pair_idx = {item_r.replica_sel, item_r.slot_sel + 1'b1};
  assign beta_rd  = beta_r[rd_slot];
  assign en_rd    = en_r[rd_idx];
  assign map_rd   = map_r[rd_idx];

  assign bond_j = $signed(bond_rdata);
  assign rs_val = $signed(rs_rdata);

  assign er_phase   = (state_r inside {S_ER_ISS, S_ER_GAP});
  assign data_phase = p_vld_r && (state_r inside {S_ER_ISS, S_ER_GAP, S_M_ISS, S_M_GAP});

  // Shared adder operand selection
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      S_BW1, S_BW3: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(rs_val);
        alu_b  = ALU_W'(bond_j);
      end
      S_BW2, S_BW4: begin
        alu_a = ALU_W'(tmp_r);
        alu_b = ALU_W'(item_r.data_value);
      end
      S_ER_ISS, S_ER_GAP: begin
        alu_op = spin_rdata ? ALU_SUB : ALU_ADD;
        alu_a  = ALU_W'(row_acc_r);
        alu_b  = ALU_W'(bond_j);
      end
      S_ER_ACC: begin
        alu_op = si_r ? ALU_ADD : ALU_SUB;
        alu_a  = ALU_W'(e_acc_r);
        alu_b  = ALU_W'(row_acc_r);
      end
      S_M_ISS, S_M_GAP: begin
        alu_a = ALU_W'(sum_r);
        alu_b = ALU_W'(bond_j);
      end
      S_M_DE: begin
        // dE = s_k * (4*sum - 2*row_sum)
        alu_op = ALU_SUB;
        alu_a  = c_row_r ? (ALU_W'(sum_r) <<< 2) : (ALU_W'(rs_val) <<< 1);
        alu_b  = c_row_r ? (ALU_W'(rs_val) <<< 1) : (ALU_W'(sum_r) <<< 2);
      end
      S_M_DEC: begin
        alu_a = ALU_W'(en_rd);
        alu_b = ALU_W'(de_r);
      end
      S_T1: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'({1'b0, beta_a_r});
        alu_b  = ALU_W'({1'b0, beta_rd});
      end
      S_T2: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(ea_r);
        alu_b  = ALU_W'(eb_r);
      end
      default: ;
    endcase
  end

  imt_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Multiplier operand and acceptance decision
  assign mul_b     = (state_r == S_M_MUL) ? $signed({2'b00, beta_rd})
                                          : $signed({bd_r[BETA_W], bd_r});
  assign prod_full = de_r * mul_b;
  assign x_abs     = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign exp_ok    = exp_accept(x_abs, item_r.rand_value);
  assign m_ok      = de_r[DE_W-1] || (de_r == '0) || exp_ok;
  assign t_ok      = !prod_r[PROD_W-1] || exp_ok;

  // Bond memory ports
  always_comb begin
    bond_we    = (state_r inside {S_CLR, S_BW1, S_BW2});
    bond_wdata = (state_r == S_CLR) ? '0 : item_r.data_value;
    case (state_r)
      S_CLR:   bond_waddr = clr_r;
      S_BW1:   bond_waddr = {item_r.row_idx, item_r.col_idx};
      default: bond_waddr = {item_r.col_idx, item_r.row_idx};
    endcase
    // BW2 reads the mirrored entry before its own write lands
    case (state_r)
      S_BW0:    bond_raddr = {item_r.row_idx, item_r.col_idx};
      S_BW2:    bond_raddr = {item_r.col_idx, item_r.row_idx};
      S_ER_ISS: bond_raddr = {i_r, j_r};
      default:  bond_raddr = {item_r.row_idx, j_r};
    endcase
  end

  // Spin memory ports
  always_comb begin
    spin_we = (state_r == S_CLR)
           || (state_r == S_MAP && item_r.func == FN_SPIN)
           || (state_r == S_M_DEC && m_ok);
    if (state_r == S_CLR) begin
      spin_waddr = clr_r[SPIN_AW-1:0];
      spin_wdata = 1'b0;
    end else if (state_r == S_MAP) begin
      spin_waddr = {item_r.replica_sel, map_rd, item_r.row_idx};
      spin_wdata = item_r.data_value[0];
    end else begin
      spin_waddr = {item_r.replica_sel, bank_r, item_r.row_idx};
      spin_wdata = !c_row_r;
    end
    spin_raddr = {item_r.replica_sel, bank_r, j_r};
  end

  // Row-sum memory ports
  always_comb begin
    rs_we    = (state_r inside {S_CLR, S_BW2, S_BW4});
    rs_wdata = (state_r == S_CLR) ? '0 : alu_y[RSUM_W-1:0];
    case (state_r)
      S_CLR:   rs_waddr = clr_r[SPIN_W-1:0];
      S_BW4:   rs_waddr = item_r.col_idx;
      default: rs_waddr = item_r.row_idx;
    endcase
    rs_raddr = (state_r inside {S_BW2, S_BW3}) ? item_r.col_idx : item_r.row_idx;
  end

  imt_ram #(.WIDTH(BOND_W), .DEPTH(BOND_DEPTH)) u_bond_ram (
    .clk   (clk),
    .we    (bond_we),
    .waddr (bond_waddr),
    .wdata (bond_wdata),
    .raddr (bond_raddr),
    .rdata (bond_rdata)
  );

  imt_ram #(.WIDTH(1), .DEPTH(SPIN_DEPTH)) u_spin_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (spin_waddr),
    .wdata (spin_wdata),
    .raddr (spin_raddr),
    .rdata (spin_rdata)
  );

  imt_ram #(.WIDTH(RSUM_W), .DEPTH(SPINS)) u_rsum_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  // Sequencer and slot map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        map_r[k] <= SLOT_W'(k % TEMPS);
      end
    end else begin
      // DONE drives out_valid_r itself
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BOND_AW'(BOND_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            case (in_data.func)
              FN_BOND:                      state_r <= S_BW0;
              FN_SPIN, FN_ENERGY, FN_METRO: state_r <= S_MAP;
              FN_TEMPER: state_r <= (in_data.slot_sel == TOP_SLOT) ? S_DONE : S_T0;
              default:                      state_r <= S_DONE;
            endcase
          end
        end
        S_MAP: begin
          i_r     <= '0;
          j_r     <= '0;
          p_vld_r <= 1'b0;
          case (item_r.func)
            FN_ENERGY: state_r <= S_ER_ISS;
            FN_METRO:  state_r <= S_M_ISS;
            default:   state_r <= S_DONE;
          endcase
        end
        S_BW0: state_r <= S_BW1;
        S_BW1: state_r <= S_BW2;
        S_BW2: state_r <= (item_r.col_idx != item_r.row_idx) ? S_BW3 : S_DONE;
        S_BW3: state_r <= S_BW4;
        S_BW4: state_r <= S_DONE;
        S_ER_ISS: begin
          p_vld_r <= 1'b1;
          if (j_r == LAST_SPIN) begin
            state_r <= S_ER_GAP;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_ER_GAP: begin
          p_vld_r <= 1'b0;
          state_r <= S_ER_ACC;
        end
        S_ER_ACC: begin
          if (i_r == LAST_SPIN) begin
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            j_r     <= i_r + 1'b1;
            state_r <= S_ER_ISS;
          end
        end
        S_M_ISS: begin
          p_vld_r <= 1'b1;
          if (j_r == LAST_SPIN) begin
            state_r <= S_M_GAP;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_M_GAP: begin
          p_vld_r <= 1'b0;
          state_r <= S_M_DE;
        end
        S_M_DE:  state_r <= S_M_MUL;
        S_M_MUL: state_r <= S_M_DEC;
        S_M_DEC: state_r <= S_DONE;
        S_T0:    state_r <= S_T1;
        S_T1:    state_r <= S_T2;
        S_T2:    state_r <= S_T3;
        S_T3:    state_r <= S_T4;
        S_T4: begin
          if (t_ok) begin
            map_r[rd_idx]   <= mb_r;
            map_r[pair_idx] <= ma_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r  <= in_data;
      acc_r   <= 1'b0;
      delta_r <= '0;
      if (in_data.func == FN_BETA) begin
        beta_r[in_data.slot_sel] <= in_data.data_value;
      end
    end

    // Row accumulation over streamed bond/spin reads
    if (data_phase) begin
      if (er_phase) begin
        if (p_diag_r) begin
          row_acc_r <= RSUM_W'(bond_j);
          si_r      <= spin_rdata;
        end else begin
          row_acc_r <= alu_y[RSUM_W-1:0];
        end
      end else begin
        if (p_diag_r) begin
          c_row_r <= spin_rdata;
        end else if (spin_rdata) begin
          sum_r <= alu_y[RSUM_W-1:0];
        end
      end
    end

    case (state_r)
      S_MAP: begin
        bank_r  <= map_rd;
        e_acc_r <= '0;
        sum_r   <= '0;
      end
      S_BW1, S_BW3: tmp_r <= alu_y[RSUM_W-1:0];
      S_ER_ISS:     p_diag_r <= (j_r == i_r);
      S_M_ISS:      p_diag_r <= (j_r == item_r.row_idx);
      S_ER_ACC: begin
        e_acc_r <= alu_y[EN_W-1:0];
        if (i_r == LAST_SPIN) begin
          en_r[rd_idx] <= alu_y[EN_W-1:0];
        end
      end
      S_M_DE: de_r <= alu_y[DE_W-1:0];
      S_M_MUL: begin
        prod_r  <= prod_full[PROD_W-1:0];
        delta_r <= de_r[EN_W-1:0];
      end
      S_M_DEC: begin
        if (m_ok) begin
          en_r[rd_idx] <= sat32(alu_y);
          acc_r        <= 1'b1;
        end
      end
      S_T0: begin
        beta_a_r <= beta_rd;
        ea_r     <= en_rd;
        ma_r     <= map_rd;
      end
      S_T1: begin
        bd_r <= alu_y[BETA_W:0];
        eb_r <= en_rd;
        mb_r <= map_rd;
      end
      S_T2: begin
        de_r    <= alu_y[DE_W-1:0];
        delta_r <= sat32(alu_y);
      end
      S_T3: prod_r <= prod_full[PROD_W-1:0];
      S_T4: begin
        if (t_ok) begin
          en_r[rd_idx]   <= eb_r;
          en_r[pair_idx] <= ea_r;
          acc_r          <= 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r.accepted        <= acc_r;
          out_data_r.slot_energy_out <= (item_r.func <= FN_TEMPER) ? en_rd : '0;
          out_data_r.delta_out       <= delta_r;
        end
      end
      default: ;
    endcase
  end

endmodule
